### hdl/lcs_pkg.sv
// shared types and constants of the line centroid steering block
// no dependencies; the files that use it refer to it by scoped names
`default_nettype none

package lcs_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LUMA_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEER_DIVISOR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_SPEED  = 3'd4;

	// reset values of the registers
	localparam logic [7:0]  RST_LUMA_THRESHOLD = 8'd100;
	localparam logic [11:0] RST_FRAME_WIDTH    = 12'd640;
	localparam logic [11:0] RST_FRAME_HEIGHT   = 12'd480;
	localparam logic [9:0]  RST_STEER_DIVISOR  = 10'd100;
	localparam logic [15:0] RST_FORWARD_SPEED  = 16'd51;

	// fixed-point luma weights, 14 fractional bits
	localparam int LUMA_W = 22;
	localparam logic [LUMA_W-1:0] LUMA_WR    = 22'd4899;
	localparam logic [LUMA_W-1:0] LUMA_WG    = 22'd9617;
	localparam logic [LUMA_W-1:0] LUMA_WB    = 22'd1868;
	localparam logic [LUMA_W-1:0] LUMA_ROUND = 22'd8192;

	// commands from controller to datapath
	typedef struct packed {
		logic pix_take;
		logic start_xy;
		logic start_t;
		logic load_out;
	} lcs_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic next_last;
		logic frame_end;
		logic busy_xy;
		logic busy_t;
	} lcs_stat_t;

endpackage

`default_nettype wire

### hdl/lcs_if.sv
// valid/ready channel interfaces: pixel words in, steering result words out
// no dependencies
`default_nettype none

interface lcs_pixel_if;
	logic       valid;
	logic       ready;
	logic [7:0] blue;
	logic [7:0] green;
	logic [7:0] red;

	modport source (output valid, blue, green, red, input ready);
	modport sink (input valid, blue, green, red, output ready);
endinterface

interface lcs_result_if;
	logic               valid;
	logic               ready;
	logic               line_found;
	logic [18:0]        centroid_x;
	logic [18:0]        centroid_y;
	logic [15:0]        speed_out;
	logic signed [15:0] turn_rate;

	modport source (output valid, line_found, centroid_x, centroid_y, speed_out, turn_rate,
		input ready);
	modport sink (input valid, line_found, centroid_x, centroid_y, speed_out, turn_rate,
		output ready);
endinterface

`default_nettype wire

### hdl/line_centroid_steering_top.sv
// top level of the line centroid steering block
// depends on lcs_pkg, lcs_if, lcs_div, lcs_ctrl and lcs_dp
//
//  channel   dir  word                                           accepted when
//  pixel     in   blue, green, red                               valid && ready
//  result    out  line_found, centroid_x/y, speed_out, turn_rate valid && ready
//  cfg       in   cfg_index, cfg_data                            cfg_we
//
// one pixel word per cycle; the luma, threshold and sums take three stages
// after the last pixel of a frame the result word follows once the two dividers
// for the centroid, run side by side, and then the steering divider are done,
// one quotient bit per cycle
// the next frame streams in meanwhile; only its last pixel is held back while
// an earlier frame end is still in the dividers or waiting for the output word
// reset loads the register defaults and clears counters and sums at once
`default_nettype none

module line_centroid_steering_top #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data,
	lcs_pixel_if.sink                         pixel,
	lcs_result_if.source                      result
);

	lcs_pkg::lcs_cmd_t  cmd;
	lcs_pkg::lcs_stat_t stat;

	lcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.in_ready  (pixel.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	lcs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.blue       (pixel.blue),
		.green      (pixel.green),
		.red        (pixel.red),
		.cmd        (cmd),
		.stat       (stat),
		.line_found (result.line_found),
		.centroid_x (result.centroid_x),
		.centroid_y (result.centroid_y),
		.speed_out  (result.speed_out),
		.turn_rate  (result.turn_rate)
	);

endmodule

`default_nettype wire

### hdl/lcs_div.sv
// restoring divider, one quotient bit per cycle
// no dependencies; quotient must fit QUO_W bits (num >> QUO_W below den)
`default_nettype none

module lcs_div #(
	parameter int NUM_W = 42,
	parameter int DEN_W = 23,
	parameter int QUO_W = 19
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  busy,
	output logic [QUO_W-1:0]      quo
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] shf_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, shf_q[QUO_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// upper numerator bits seed the remainder, low bits shift through
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DEN_W'(num >> QUO_W);
			shf_q <= num[QUO_W-1:0];
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			shf_q <= {shf_q[QUO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = shf_q;

endmodule

`default_nettype wire

### hdl/lcs_ctrl.sv
// controller: pixel acceptance, frame-end sequencing, output word valid
// depends on lcs_pkg
`default_nettype none

module lcs_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire lcs_pkg::lcs_stat_t stat,
	output lcs_pkg::lcs_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_DIV_XY = 2'd1;
	localparam logic [1:0] ST_DIV_T  = 2'd2;
	localparam logic [1:0] ST_HOLD   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       pending_q;
	logic       out_valid_q;

	// a frame's last pixel waits while an earlier frame end is unfinished
	assign in_ready = !(pending_q && stat.next_last);

	always_comb begin
		cmd          = '0;
		cmd.pix_take = in_valid && in_ready;
		state_d      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (stat.frame_end) begin
					cmd.start_xy = 1'b1;
					state_d      = ST_DIV_XY;
				end
			end
			ST_DIV_XY: begin
				if (!stat.busy_xy) begin
					cmd.start_t = 1'b1;
					state_d     = ST_DIV_T;
				end
			end
			ST_DIV_T: begin
				if (!stat.busy_t) begin
					state_d = ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pix_take && stat.next_last) begin
				pending_q <= 1'b1;
			end else if (cmd.load_out) begin
				pending_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

### hdl/lcs_dp.sv
// datapath: config registers, luma pipeline, position counters, sums,
// centroid and steering dividers, output word register
// depends on lcs_pkg and lcs_div
`default_nettype none

module lcs_dp #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic [7:0]                   blue,
	input  wire logic [7:0]                   green,
	input  wire logic [7:0]                   red,
	input  wire lcs_pkg::lcs_cmd_t            cmd,
	output lcs_pkg::lcs_stat_t                stat,
	output logic                              line_found,
	output logic [18:0]                       centroid_x,
	output logic [18:0]                       centroid_y,
	output logic [15:0]                       speed_out,
	output logic signed [15:0]                turn_rate
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
	localparam int CSUM_W = CNT_W + COL_W;
	localparam int RSUM_W = CNT_W + ROW_W;
	localparam int QX_W   = COL_W + 8;
	localparam int QY_W   = ROW_W + 8;
	localparam int SAT_W  = (QX_W >= 17) ? QX_W : 17;
	localparam int LW     = lcs_pkg::LUMA_W;

	// configuration
	logic [7:0]  thr_q;
	logic [11:0] fw_q;
	logic [11:0] fh_q;
	logic [9:0]  sdiv_q;
	logic [15:0] spd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= lcs_pkg::RST_LUMA_THRESHOLD;
			fw_q   <= lcs_pkg::RST_FRAME_WIDTH;
			fh_q   <= lcs_pkg::RST_FRAME_HEIGHT;
			sdiv_q <= lcs_pkg::RST_STEER_DIVISOR;
			spd_q  <= lcs_pkg::RST_FORWARD_SPEED;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcs_pkg::REG_LUMA_THRESHOLD: thr_q  <= cfg_data[7:0];
				lcs_pkg::REG_FRAME_WIDTH:    fw_q   <= cfg_data[11:0];
				lcs_pkg::REG_FRAME_HEIGHT:   fh_q   <= cfg_data[11:0];
				lcs_pkg::REG_STEER_DIVISOR:  sdiv_q <= cfg_data[9:0];
				lcs_pkg::REG_FORWARD_SPEED:  spd_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// effective frame size minus one, zero acts as one, clamped to the maxima
	logic [COL_W-1:0] w_m1;
	logic [ROW_W-1:0] h_m1;
	logic [COL_W:0]   w_eff;
	logic [COL_W-1:0] half_w;

	always_comb begin
		if (fw_q == 12'd0) begin
			w_m1 = '0;
		end else if ({1'b0, fw_q} > 13'(MAX_WIDTH)) begin
			w_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_m1 = COL_W'(fw_q - 12'd1);
		end
		if (fh_q == 12'd0) begin
			h_m1 = '0;
		end else if ({1'b0, fh_q} > 13'(MAX_HEIGHT)) begin
			h_m1 = ROW_W'(MAX_HEIGHT - 1);
		end else begin
			h_m1 = ROW_W'(fh_q - 12'd1);
		end
	end

	assign w_eff  = {1'b0, w_m1} + 1'b1;
	assign half_w = w_eff[COL_W:1];

	// position counters, advanced on every accepted pixel
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             row_end;
	logic             next_last;

	assign row_end   = col_q >= w_m1;
	assign next_last = row_end && (row_q >= h_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.pix_take) begin
			if (!row_end) begin
				col_q <= col_q + 1'b1;
			end else if (!next_last) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// stage 1: weighted channels
	logic [LW-1:0]    pr_s1, pg_s1, pb_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             last_s1;
	logic             valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.pix_take;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix_take) begin
			pr_s1   <= LW'(red) * lcs_pkg::LUMA_WR;
			pg_s1   <= LW'(green) * lcs_pkg::LUMA_WG;
			pb_s1   <= LW'(blue) * lcs_pkg::LUMA_WB;
			col_s1  <= col_q;
			row_s1  <= row_q;
			last_s1 <= next_last;
		end
	end

	// stage 2: luma and threshold
	logic [LW-1:0]    luma_sum;
	logic             line_s2;
	logic             last_s2;
	logic             valid_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;

	assign luma_sum = pr_s1 + pg_s1 + pb_s1 + lcs_pkg::LUMA_ROUND;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			line_s2 <= luma_sum[LW-1:14] <= thr_q;
			last_s2 <= last_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
		end
	end

	// stage 3: accumulate; the last pixel hands the totals to the job registers
	logic [CNT_W-1:0]  cnt_q;
	logic [CSUM_W-1:0] csum_q;
	logic [RSUM_W-1:0] rsum_q;
	logic [CNT_W-1:0]  cnt_nx;
	logic [CSUM_W-1:0] csum_nx;
	logic [RSUM_W-1:0] rsum_nx;
	logic [CNT_W-1:0]  cnt_job_q;
	logic [CSUM_W-1:0] csum_job_q;
	logic [RSUM_W-1:0] rsum_job_q;
	logic              end_q;

	assign cnt_nx  = cnt_q + CNT_W'(line_s2);
	assign csum_nx = csum_q + (line_s2 ? CSUM_W'(col_s2) : '0);
	assign rsum_nx = rsum_q + (line_s2 ? RSUM_W'(row_s2) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			csum_q <= '0;
			rsum_q <= '0;
			end_q  <= 1'b0;
		end else begin
			end_q <= valid_s2 && last_s2;
			if (valid_s2) begin
				if (last_s2) begin
					cnt_q  <= '0;
					csum_q <= '0;
					rsum_q <= '0;
				end else begin
					cnt_q  <= cnt_nx;
					csum_q <= csum_nx;
					rsum_q <= rsum_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && last_s2) begin
			cnt_job_q  <= cnt_nx;
			csum_job_q <= csum_nx;
			rsum_job_q <= rsum_nx;
		end
	end

	// centroid dividers
	logic [QX_W-1:0] quo_x;
	logic [QY_W-1:0] quo_y;
	logic            busy_x, busy_y;

	lcs_div #(
		.NUM_W (CSUM_W + 8),
		.DEN_W (CNT_W),
		.QUO_W (QX_W)
	) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_xy),
		.num    ({csum_job_q, 8'd0}),
		.den    (cnt_job_q),
		.busy   (busy_x),
		.quo    (quo_x)
	);

	lcs_div #(
		.NUM_W (RSUM_W + 8),
		.DEN_W (CNT_W),
		.QUO_W (QY_W)
	) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_xy),
		.num    ({rsum_job_q, 8'd0}),
		.den    (cnt_job_q),
		.busy   (busy_y),
		.quo    (quo_y)
	);

	// steering: |cx - half width| over the divisor, sign applied afterwards
	logic [QX_W-1:0] half_q8;
	logic            err_pos;
	logic [QX_W-1:0] err_mag;
	logic [9:0]      sdiv_eff;
	logic [QX_W-1:0] quo_t;
	logic            busy_t;

	assign half_q8  = {half_w, 8'd0};
	assign err_pos  = quo_x > half_q8;
	assign err_mag  = err_pos ? (quo_x - half_q8) : (half_q8 - quo_x);
	assign sdiv_eff = (sdiv_q == 10'd0) ? 10'd1 : sdiv_q;

	lcs_div #(
		.NUM_W (QX_W),
		.DEN_W (10),
		.QUO_W (QX_W)
	) u_div_t (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start_t),
		.num    (err_mag),
		.den    (sdiv_eff),
		.busy   (busy_t),
		.quo    (quo_t)
	);

	// saturate to 16 bits; a positive error steers negative
	logic [SAT_W-1:0]   quo_t_ext;
	logic signed [15:0] turn_sat;

	assign quo_t_ext = SAT_W'(quo_t);

	always_comb begin
		if (err_pos) begin
			if (quo_t_ext >= SAT_W'(32768)) begin
				turn_sat = 16'sh8000;
			end else begin
				turn_sat = $signed(~quo_t_ext[15:0] + 16'd1);
			end
		end else begin
			if (quo_t_ext > SAT_W'(32767)) begin
				turn_sat = 16'sh7fff;
			end else begin
				turn_sat = $signed(quo_t_ext[15:0]);
			end
		end
	end

	// output word register
	logic found;

	assign found = cnt_job_q != '0;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			line_found <= found;
			centroid_x <= found ? 19'(quo_x) : 19'd0;
			centroid_y <= found ? 19'(quo_y) : 19'd0;
			speed_out  <= spd_q;
			turn_rate  <= found ? turn_sat : 16'sd0;
		end
	end

	assign stat.next_last = next_last;
	assign stat.frame_end = end_q;
	assign stat.busy_xy   = busy_x || busy_y;
	assign stat.busy_t    = busy_t;

endmodule

`default_nettype wire

### tb/sv/tb_lcs_checker.sv
`timescale 1ns / 100ps
// scoreboard for the line centroid steering block: tracks pixel words and predicts result words
// depends on lcs_pkg for the register indexes and luma weights, and on lcs_if for the channels

module tb_lcs_checker #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lcs_pkg::CFG_DATA_W-1:0]   cfg_data,
	lcs_pixel_if                             pixel,
	lcs_result_if                            result,
	output int                               fails,
	output int                               pending
);

	typedef struct packed {
		logic               found;
		logic [18:0]        cx;
		logic [18:0]        cy;
		logic [15:0]        speed;
		logic signed [15:0] turn;
	} steer_word_t;

	// register copies
	logic [7:0]  thr_reg;
	logic [11:0] width_reg;
	logic [11:0] height_reg;
	logic [9:0]  div_reg;
	logic [15:0] speed_reg;

	// frame position and accumulators
	logic [10:0] col;
	logic [10:0] row;
	logic [22:0] hits;
	logic [33:0] col_sum;
	logic [33:0] row_sum;

	steer_word_t steer_queue[$];
	steer_word_t want;
	steer_word_t got;
	steer_word_t word;
	bit          frame_done;
	int          frame_no;

	function automatic logic [11:0] eff_size(input logic [11:0] v, input int max_v);
		if (v == 12'd0)
			return 12'd1;
		if (int'(v) > max_v)
			return 12'(max_v);
		return v;
	endfunction

	task automatic track_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
		output bit done, output steer_word_t w_out);
		logic [21:0] y;
		logic [11:0] w;
		logic [11:0] h;
		logic [41:0] qx;
		logic [41:0] qy;
		longint      err;
		longint      t;
		longint      d;
		y = (22'(r) * lcs_pkg::LUMA_WR + 22'(g) * lcs_pkg::LUMA_WG
			+ 22'(b) * lcs_pkg::LUMA_WB + lcs_pkg::LUMA_ROUND) >> 14;
		w = eff_size(width_reg, MAX_WIDTH);
		h = eff_size(height_reg, MAX_HEIGHT);
		done = 1'b0;
		w_out = '0;
		if (y <= 22'(thr_reg)) begin
			hits = hits + 23'd1;
			col_sum = col_sum + 34'(col);
			row_sum = row_sum + 34'(row);
		end
		// a shrunk size mid-frame ends the row or frame at once
		if ({1'b0, col} < w - 12'd1) begin
			col = col + 11'd1;
		end else if ({1'b0, row} < h - 12'd1) begin
			col = '0;
			row = row + 11'd1;
		end else begin
			done = 1'b1;
			w_out.speed = speed_reg;
			if (hits != '0) begin
				d = (div_reg == '0) ? 64'sd1 : longint'(div_reg);
				qx = {col_sum, 8'd0} / 42'(hits);
				qy = {row_sum, 8'd0} / 42'(hits);
				err = longint'(qx) - longint'(w >> 1) * 256;
				t = -err / d;
				if (t > 32767)
					t = 32767;
				else if (t < -32768)
					t = -32768;
				w_out.found = 1'b1;
				w_out.cx = qx[18:0];
				w_out.cy = qy[18:0];
				w_out.turn = t[15:0];
			end
			col = '0;
			row = '0;
			hits = '0;
			col_sum = '0;
			row_sum = '0;
		end
	endtask

	task automatic check_field(input string field, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			fails++;
			$display("%0t: frame %0d %s expected %0d, got %0d", $time, frame_no, field,
				want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_reg = lcs_pkg::RST_LUMA_THRESHOLD;
			width_reg = lcs_pkg::RST_FRAME_WIDTH;
			height_reg = lcs_pkg::RST_FRAME_HEIGHT;
			div_reg = lcs_pkg::RST_STEER_DIVISOR;
			speed_reg = lcs_pkg::RST_FORWARD_SPEED;
			col = '0;
			row = '0;
			hits = '0;
			col_sum = '0;
			row_sum = '0;
			steer_queue.delete();
			fails = 0;
			frame_no = 0;
		end else begin
			// result first, so a word can never match an expectation queued at the same edge
			if (result.valid && result.ready) begin
				got.found = result.line_found;
				got.cx = result.centroid_x;
				got.cy = result.centroid_y;
				got.speed = result.speed_out;
				got.turn = result.turn_rate;
				if (steer_queue.size() == 0) begin
					fails++;
					$display("%0t: result word with no frame end waiting, got %p", $time, got);
				end else begin
					want = steer_queue.pop_front();
					check_field("line_found", want.found, got.found);
					check_field("centroid_x", want.cx, got.cx);
					check_field("centroid_y", want.cy, got.cy);
					check_field("speed_out", want.speed, got.speed);
					check_field("turn_rate", longint'($signed(want.turn)),
						longint'($signed(got.turn)));
				end
				frame_no++;
			end
			if (pixel.valid && pixel.ready) begin
				track_pixel(pixel.blue, pixel.green, pixel.red, frame_done, word);
				if (frame_done)
					steer_queue.push_back(word);
			end
			if (cfg_we) begin
				case (cfg_index)
					lcs_pkg::REG_LUMA_THRESHOLD: thr_reg = cfg_data[7:0];
					lcs_pkg::REG_FRAME_WIDTH:    width_reg = cfg_data[11:0];
					lcs_pkg::REG_FRAME_HEIGHT:   height_reg = cfg_data[11:0];
					lcs_pkg::REG_STEER_DIVISOR:  div_reg = cfg_data[9:0];
					lcs_pkg::REG_FORWARD_SPEED:  speed_reg = cfg_data[15:0];
					default: ;
				endcase
			end
		end
		pending = steer_queue.size();
	end

endmodule

### tb/sv/tb_line_centroid_steering_top.sv
`timescale 1ns / 100ps
// testbench top for line_centroid_steering_top: drives pixel words and register writes
// depends on lcs_pkg, lcs_if, the block itself and tb_lcs_checker, which does the comparing

module tb_line_centroid_steering_top;

	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 30;
	localparam int WIDE_ROW     = 260;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [lcs_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           rx_ready = 1'b0;
	int                             send_idle_pct = 0;
	int                             rx_stall_pct = 0;
	int                             quiet_cycles = 0;
	int                             fails;
	int                             pending;

	lcs_pixel_if  pixel_ch();
	lcs_result_if result_ch();

	assign result_ch.ready = rx_ready;

	always #5 clk = ~clk;

	line_centroid_steering_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.result    (result_ch)
	);

	tb_lcs_checker scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixel     (pixel_ch),
		.result    (result_ch),
		.fails     (fails),
		.pending   (pending)
	);

	always @(negedge clk) begin
		rx_ready = ($urandom_range(99) >= rx_stall_pct);
	end

	// watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if ((pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_line_centroid_steering_top: errors");
			$finish;
		end
	end

	task automatic set_idling(input idle_mode_t m);
		case (m)
			IDLE_NONE:     begin send_idle_pct = 0;  rx_stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 81; rx_stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  rx_stall_pct = 81; end
			default:       begin send_idle_pct = 12; rx_stall_pct = 12; end
		endcase
	endtask

	task automatic write_reg(input logic [lcs_pkg::CFG_IDX_W-1:0] idx,
		input logic [lcs_pkg::CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		@(negedge clk);
	endtask

	// unused upper bits get random junk, the block must mask them
	task automatic configure(input logic [7:0] thr, input logic [11:0] fw, input logic [11:0] fh,
		input logic [9:0] dv, input logic [15:0] spd);
		write_reg(lcs_pkg::REG_LUMA_THRESHOLD, {8'($urandom), thr});
		write_reg(lcs_pkg::REG_FRAME_WIDTH, {4'($urandom), fw});
		write_reg(lcs_pkg::REG_FRAME_HEIGHT, {4'($urandom), fh});
		write_reg(lcs_pkg::REG_STEER_DIVISOR, {6'($urandom), dv});
		write_reg(lcs_pkg::REG_FORWARD_SPEED, spd);
	endtask

	task automatic wait_results();
		pixel_ch.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// wait until every frame end has given its result word, then let the block idle
	task automatic drain();
		wait_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r);
		while ($urandom_range(99) < send_idle_pct) begin
			pixel_ch.valid = 1'b0;
			@(negedge clk);
		end
		pixel_ch.valid = 1'b1;
		pixel_ch.blue = b;
		pixel_ch.green = g;
		pixel_ch.red = r;
		do
			@(posedge clk);
		while (!pixel_ch.ready);
		@(negedge clk);
	endtask

	task automatic random_pixel(input int dark_pct);
		logic [7:0] b;
		logic [7:0] g;
		logic [7:0] r;
		if ($urandom_range(3) == 0) begin
			{b, g, r} = 24'($urandom);
		end else if ($urandom_range(99) < dark_pct) begin
			b = 8'($urandom_range(0, 40));
			g = 8'($urandom_range(0, 40));
			r = 8'($urandom_range(0, 40));
		end else begin
			b = 8'($urandom_range(180, 255));
			g = 8'($urandom_range(180, 255));
			r = 8'($urandom_range(180, 255));
		end
		send_pixel(b, g, r);
	endtask

	initial begin
		logic [7:0]  thr;
		logic [11:0] fw;
		logic [11:0] fh;
		logic [9:0]  dv;
		int          dark;
		pixel_ch.valid = 1'b0;
		pixel_ch.blue = '0;
		pixel_ch.green = '0;
		pixel_ch.red = '0;
		set_idling(IDLE_NONE);
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// zero width acts as one, divisor zero acts as one, top threshold marks white as line
		configure(8'd255, 12'd0, 12'd1, 10'd0, 16'hFFFF);
		send_pixel(8'hFF, 8'hFF, 8'hFF);
		drain();

		// threshold zero: only black is line, single channels at full scale are not
		configure(8'd0, 12'd1, 12'd1, 10'd0, 16'd0);
		send_pixel(8'h00, 8'h00, 8'h00);
		send_pixel(8'h01, 8'h01, 8'h01);
		send_pixel(8'hFF, 8'h00, 8'h00);
		send_pixel(8'h00, 8'hFF, 8'h00);
		send_pixel(8'h00, 8'h00, 8'hFF);
		drain();

		// 4x2 frames, line right of centre then left of centre
		configure(8'd100, 12'd4, 12'd2, 10'd1, 16'd51);
		for (int i = 0; i < 8; i++) begin
			if (i == 3)
				send_pixel(8'h00, 8'h00, 8'h00);
			else
				send_pixel(8'hFF, 8'hFF, 8'hFF);
		end
		for (int i = 0; i < 8; i++) begin
			if (i == 4)
				send_pixel(8'h00, 8'h00, 8'h00);
			else
				send_pixel(8'hFF, 8'hFF, 8'hFF);
		end

		// width shrunk while partway into the second row
		for (int i = 0; i < 5; i++)
			send_pixel(8'h00, 8'h00, 8'h00);
		drain();
		write_reg(lcs_pkg::REG_FRAME_WIDTH, 16'd1);
		send_pixel(8'h00, 8'h00, 8'h00);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			set_idling(idle_mode_t'(ph % 4));
			case ($urandom_range(3))
				0:       thr = 8'd0;
				1:       thr = 8'd255;
				default: thr = 8'($urandom);
			endcase
			fw = ($urandom_range(15) == 0) ? 12'd0 : 12'($urandom_range(1, 8));
			fh = ($urandom_range(15) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
			case ($urandom_range(3))
				0:       dv = 10'd1;
				1:       dv = 10'd1023;
				2:       dv = 10'd0;
				default: dv = 10'($urandom_range(1, 1023));
			endcase
			configure(thr, fw, fh, dv, 16'($urandom));
			if (ph % 3 == 0)
				write_reg(lcs_pkg::CFG_IDX_W'(int'(lcs_pkg::REG_FORWARD_SPEED)
					+ $urandom_range(1, 3)), 16'($urandom));
			dark = $urandom_range(0, 100);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (ph == 5 && k == PHASE_ITEMS / 2)
					wait_results();
				random_pixel(dark);
			end
		end

		// one-pixel frame to close whatever frame is open
		drain();
		set_idling(IDLE_NONE);
		configure(8'd0, 12'd1, 12'd1, 10'd1, 16'd0);
		random_pixel(50);
		drain();

		// wide row, line at either edge drives the turn rate into saturation
		configure(8'd0, 12'(WIDE_ROW), 12'd1, 10'd1, 16'h8000);
		for (int i = 0; i < WIDE_ROW; i++) begin
			if (i == 0)
				send_pixel(8'h00, 8'h00, 8'h00);
			else
				send_pixel(8'hFF, 8'hFF, 8'hFF);
		end
		for (int i = 0; i < WIDE_ROW; i++) begin
			if (i == WIDE_ROW - 1)
				send_pixel(8'h00, 8'h00, 8'h00);
			else
				send_pixel(8'hFF, 8'hFF, 8'hFF);
		end
		drain();

		if (fails == 0)
			$display("tb_line_centroid_steering_top: clean");
		else
			$display("tb_line_centroid_steering_top: errors");
		$finish;
	end

endmodule

### files.f
hdl/lcs_pkg.sv
hdl/lcs_if.sv
hdl/lcs_div.sv
hdl/lcs_ctrl.sv
hdl/lcs_dp.sv
hdl/line_centroid_steering_top.sv
tb/sv/tb_lcs_checker.sv
tb/sv/tb_line_centroid_steering_top.sv
